>>> rtl/assert_macros.svh
// Assertion macros shared by the block's RTL modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define LDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define LDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lds_pkg.sv
// Types and constants for the Lemoine decomposition search block.
// Used by lds_ctrl, lds_dpath and lemoine_decomposition_search_top.
package lds_pkg;

    localparam int MAX_N_DEF = 65535;
    localparam int N_W       = 16;
    localparam int CNT_W     = N_W + 1;
    localparam int Q_W       = N_W - 1;
    localparam int ST_W      = 2;
    localparam int SF_W      = 2;

    localparam logic [N_W-1:0]   MIN_N        = N_W'(5);
    localparam logic [CNT_W-1:0] FIRST_P      = CNT_W'(3);
    localparam logic [CNT_W-1:0] FIRST_SIEVE  = CNT_W'(2);
    localparam logic [CNT_W-1:0] FIRST_SQUARE = CNT_W'(4);
    localparam logic [CNT_W-1:0] SCAN_MARGIN  = CNT_W'(4);
    localparam logic [SF_W-1:0]  SMALL_FACTOR = SF_W'(2);

    typedef enum logic [ST_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_NONE    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic    load_n;
        logic    init_start;
        logic    init_step;
        logic    sv_start;
        logic    rd_i;
        logic    mark_start;
        logic    mark_step;
        logic    sv_next;
        logic    sc_start;
        logic    rd_p;
        logic    rd_q;
        logic    sc_next;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        logic in_ok;
        logic init_last;
        logic sv_more;
        logic rd_bit;
        logic mark_more;
        logic sc_more;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/lemoine_decomposition_search_top.sv
// Lemoine decomposition search block: top level joining lds_ctrl and lds_dpath.
// Depends on lds_pkg, lds_ctrl and lds_dpath.
//
// Input channel: i_valid, o_stall, i_n_value. A word is taken when i_valid is
// high and o_stall low; o_stall is low only while the block is idle.
// Output channel: o_valid, i_stall and the result fields; a word moves when
// o_valid is high and i_stall low. One result word per input word.
// Steps for a valid odd n: preset the bitmap over entries 0..n, then sieve each
// index i with i*i <= n, marking the composites of each prime i, then scan the
// odd p for a prime p with (n-p)/2 prime, then hand the result off; all of this
// is paced by the single bitmap port (one access per cycle). An invalid input
// (even, five or below, above MAX_N) goes straight to the result handoff.
// One search runs at a time; the next word is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// A stalled result holds until taken; a finished search waits in the
// controller while the output register is full and stalled.
// Reset is synchronous, active low; the bitmap needs no clearing pass since
// each search rewrites entries 0..n before reading them.
module lemoine_decomposition_search_top
    import lds_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [N_W-1:0]   i_n_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ST_W-1:0]  o_status,
    output logic [N_W-1:0]   o_odd_prime,
    output logic [N_W-1:0]   o_semiprime,
    output logic [SF_W-1:0]  o_small_factor,
    output logic [Q_W-1:0]   o_large_factor
);

    t_cmd  cmd;
    t_stat stat;

    lds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lds_dpath #(
        .MAX_N (MAX_N)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n_value      (i_n_value),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_odd_prime    (o_odd_prime),
        .o_semiprime    (o_semiprime),
        .o_small_factor (o_small_factor),
        .o_large_factor (o_large_factor)
    );

endmodule

>>> rtl/lds_ctrl.sv
// Sequencer for the Lemoine decomposition search: sieve build, scan, result.
// Depends on lds_pkg and assert_macros.svh; drives lds_dpath by command struct.
`include "assert_macros.svh"

module lds_ctrl
    import lds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SV_TEST,
        S_SV_CHK,
        S_MARK,
        S_SC_TEST,
        S_SC_CHKP,
        S_SC_CHKQ,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_kind,  n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.out_status = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_n = 1'b1;
                    if (i_stat.in_ok) begin
                        o_cmd.init_start = 1'b1;
                        n_state = S_INIT;
                    end else begin
                        n_kind  = ST_INVALID;
                        n_state = S_DONE;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    o_cmd.sv_start = 1'b1;
                    n_state = S_SV_TEST;
                end
            end
            S_SV_TEST: begin
                if (i_stat.sv_more) begin
                    o_cmd.rd_i = 1'b1;
                    n_state = S_SV_CHK;
                end else begin
                    o_cmd.sc_start = 1'b1;
                    n_state = S_SC_TEST;
                end
            end
            S_SV_CHK: begin
                if (i_stat.rd_bit) begin
                    o_cmd.mark_start = 1'b1;
                    n_state = S_MARK;
                end else begin
                    o_cmd.sv_next = 1'b1;
                    n_state = S_SV_TEST;
                end
            end
            S_MARK: begin
                if (i_stat.mark_more) begin
                    o_cmd.mark_step = 1'b1;
                end else begin
                    o_cmd.sv_next = 1'b1;
                    n_state = S_SV_TEST;
                end
            end
            S_SC_TEST: begin
                if (i_stat.sc_more) begin
                    o_cmd.rd_p = 1'b1;
                    n_state = S_SC_CHKP;
                end else begin
                    n_kind  = ST_NONE;
                    n_state = S_DONE;
                end
            end
            S_SC_CHKP: begin
                if (i_stat.rd_bit) begin
                    o_cmd.rd_q = 1'b1;
                    n_state = S_SC_CHKQ;
                end else begin
                    o_cmd.sc_next = 1'b1;
                    n_state = S_SC_TEST;
                end
            end
            S_SC_CHKQ: begin
                if (i_stat.rd_bit) begin
                    n_kind  = ST_FOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.sc_next = 1'b1;
                    n_state = S_SC_TEST;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ST_INVALID;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    `LDS_ASSERT_NEXT(a_accept_leaves_idle, r_state == S_IDLE && i_valid,
        r_state != S_IDLE, "accepted word did not start a search")
    `LDS_ASSERT(a_q_after_p, r_state == S_SC_CHKQ |-> $past(r_state) == S_SC_CHKP,
        "q check without a prime p")
    `LDS_ASSERT_NEXT(a_done_to_idle, r_state == S_DONE && i_stat.out_free,
        r_state == S_IDLE, "result handoff did not return to idle")

endmodule

>>> rtl/lds_dpath.sv
// Datapath for the Lemoine decomposition search: prime bitmap, counters, result register.
// Depends on lds_pkg and assert_macros.svh; sequenced by lds_ctrl.
`include "assert_macros.svh"

module lds_dpath
    import lds_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [N_W-1:0]   i_n_value,
    input  logic             i_stall,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [N_W-1:0]   o_odd_prime,
    output logic [N_W-1:0]   o_semiprime,
    output logic [SF_W-1:0]  o_small_factor,
    output logic [Q_W-1:0]   o_large_factor
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    logic             r_bitmap [DEPTH];
    logic             r_rd_bit;
    logic [N_W-1:0]   r_n;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_sq, n_sq;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_p, n_p;
    logic             r_o_valid;

    logic [CNT_W-1:0] n_ext;
    logic [N_W-1:0]   diff;
    logic [CNT_W-1:0] q_idx;
    logic             wr_en;
    logic             wr_bit;
    logic [CNT_W-1:0] wr_idx;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;

    assign n_ext = {1'b0, r_n};
    assign diff  = r_n - r_p[N_W-1:0];
    assign q_idx = CNT_W'(diff[N_W-1:1]);

    assign o_stat.in_ok     = (i_n_value > MIN_N) && i_n_value[0]
                              && (32'(i_n_value) <= 32'(MAX_N));
    assign o_stat.init_last = (r_i == n_ext);
    assign o_stat.sv_more   = (r_sq <= n_ext);
    assign o_stat.rd_bit    = r_rd_bit;
    assign o_stat.mark_more = (r_j <= n_ext);
    assign o_stat.sc_more   = (r_p + SCAN_MARGIN <= n_ext);
    assign o_stat.out_free  = !r_o_valid || !i_stall;

    always_comb begin
        n_i  = r_i;
        n_sq = r_sq;
        n_j  = r_j;
        n_p  = r_p;
        if (i_cmd.init_start) begin
            n_i = '0;
        end else if (i_cmd.sv_start) begin
            n_i  = FIRST_SIEVE;
            n_sq = FIRST_SQUARE;
        end else if (i_cmd.init_step) begin
            n_i = r_i + 1'b1;
        end else if (i_cmd.sv_next) begin
            n_i  = r_i + 1'b1;
            n_sq = r_sq + {r_i[CNT_W-2:0], 1'b1};
        end
        if (i_cmd.mark_start) begin
            n_j = r_sq;
        end else if (i_cmd.mark_step) begin
            n_j = r_j + r_i;
        end
        if (i_cmd.sc_start) begin
            n_p = FIRST_P;
        end else if (i_cmd.sc_next) begin
            n_p = r_p + CNT_W'(2);
        end
    end

    assign wr_en  = i_cmd.init_step || i_cmd.mark_step;
    assign wr_bit = i_cmd.init_step && (r_i >= FIRST_SIEVE);
    assign wr_idx = i_cmd.init_step ? r_i : r_j;
    assign rd_en  = i_cmd.rd_i || i_cmd.rd_p || i_cmd.rd_q;
    assign rd_idx = i_cmd.rd_i ? r_i : (i_cmd.rd_p ? r_p : q_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[AW'(wr_idx)] <= wr_bit;
        end
        if (rd_en) begin
            r_rd_bit <= r_bitmap[AW'(rd_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n) begin
            r_n <= i_n_value;
        end
        r_i  <= n_i;
        r_sq <= n_sq;
        r_j  <= n_j;
        r_p  <= n_p;
        if (i_cmd.out_load) begin
            o_status <= i_cmd.out_status;
            if (i_cmd.out_status == ST_FOUND) begin
                o_odd_prime    <= r_p[N_W-1:0];
                o_semiprime    <= diff;
                o_small_factor <= SMALL_FACTOR;
                o_large_factor <= diff[N_W-1:1];
            end else begin
                o_odd_prime    <= '0;
                o_semiprime    <= '0;
                o_small_factor <= '0;
                o_large_factor <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid = r_o_valid;

    `LDS_ASSERT(a_wr_in_range, wr_en |-> wr_idx <= n_ext, "bitmap write beyond n")
    `LDS_ASSERT(a_rd_in_range, rd_en |-> rd_idx <= n_ext, "bitmap read beyond n")
    `LDS_ASSERT(a_found_shape,
        r_o_valid && o_status == ST_FOUND |-> o_odd_prime[0] && !o_semiprime[0]
            && o_semiprime[N_W-1:1] == o_large_factor,
        "found result fields inconsistent")

endmodule

>>> test/lds_result_checker.sv
// Result checker for lemoine_decomposition_search_top: predicts each result word and compares.
// Depends on lds_pkg; watches both valid/stall channels and reports a failure count.
module lds_result_checker
    import lds_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  logic [N_W-1:0]  i_n_value,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  logic [ST_W-1:0] i_status,
    input  logic [N_W-1:0]  i_odd_prime,
    input  logic [N_W-1:0]  i_semiprime,
    input  logic [SF_W-1:0] i_small_factor,
    input  logic [Q_W-1:0]  i_large_factor,
    output int              o_error_count,
    output int              o_words_due
);

    typedef struct packed {
        t_status         status;
        logic [N_W-1:0]  odd_prime;
        logic [N_W-1:0]  semiprime;
        logic [SF_W-1:0] small_factor;
        logic [Q_W-1:0]  large_factor;
    } t_split;

    bit     prime_flag [0:MAX_N_DEF];
    t_split split_due [$];

    initial begin
        o_error_count = 0;
        o_words_due   = 0;
        for (int k = 0; k <= MAX_N_DEF; k++)
            prime_flag[k] = (k >= 2);
        for (int k = 2; k * k <= MAX_N_DEF; k++)
            if (prime_flag[k])
                for (int m = k * k; m <= MAX_N_DEF; m += k)
                    prime_flag[m] = 1'b0;
    end

    function automatic t_split lemoine_split(input logic [N_W-1:0] n);
        t_split      r;
        int unsigned p;
        int unsigned q;
        r.status       = ST_INVALID;
        r.odd_prime    = '0;
        r.semiprime    = '0;
        r.small_factor = '0;
        r.large_factor = '0;
        if (n <= MIN_N || !n[0] || int'(n) > MAX_N_DEF)
            return r;
        r.status = ST_NONE;
        for (p = 3; p + 4 <= n; p += 2) begin
            q = (n - p) >> 1;
            if (prime_flag[p] && prime_flag[q]) begin
                r.status       = ST_FOUND;
                r.odd_prime    = N_W'(p);
                r.semiprime    = N_W'(n - p);
                r.small_factor = SMALL_FACTOR;
                r.large_factor = Q_W'(q);
                break;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [N_W-1:0] want,
                               input logic [N_W-1:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            o_error_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_split want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                split_due.push_back(lemoine_split(i_n_value));
            if (i_out_valid && !i_out_stall) begin
                if (split_due.size() == 0) begin
                    $display("%0t: extra result word, expected nothing, actual status %0d",
                             $time, i_status);
                    o_error_count++;
                end else begin
                    want = split_due.pop_front();
                    check_field("status", N_W'(want.status), N_W'(i_status));
                    check_field("odd_prime", want.odd_prime, i_odd_prime);
                    check_field("semiprime", want.semiprime, i_semiprime);
                    check_field("small_factor", N_W'(want.small_factor), N_W'(i_small_factor));
                    check_field("large_factor", N_W'(want.large_factor), N_W'(i_large_factor));
                end
            end
        end
        o_words_due <= split_due.size();
    end

endmodule

>>> test/tb_lemoine_decomposition_search_top.sv
// Testbench top for lemoine_decomposition_search_top: clock, reset, stimulus and verdict.
// Depends on lds_pkg, the block's RTL and lds_result_checker.
module tb_lemoine_decomposition_search_top;
    import lds_pkg::*;

    localparam int HOLD_CYCLES   = 2000;
    localparam int TAIL_CYCLES   = 50;
    localparam int TIMEOUT_UNITS = 30_000_000;

    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            i_valid   = 1'b0;
    logic [N_W-1:0]  i_n_value = '0;
    logic            i_stall   = 1'b0;
    logic            o_stall;
    logic            o_valid;
    logic [ST_W-1:0] o_status;
    logic [N_W-1:0]  o_odd_prime;
    logic [N_W-1:0]  o_semiprime;
    logic [SF_W-1:0] o_small_factor;
    logic [Q_W-1:0]  o_large_factor;

    int error_count;
    int words_due;
    bit quiet_phase = 1'b0;
    bit hold_req    = 1'b0;

    lemoine_decomposition_search_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_n_value      (i_n_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_odd_prime    (o_odd_prime),
        .o_semiprime    (o_semiprime),
        .o_small_factor (o_small_factor),
        .o_large_factor (o_large_factor)
    );

    lds_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_n_value      (i_n_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_status       (o_status),
        .i_odd_prime    (o_odd_prime),
        .i_semiprime    (o_semiprime),
        .i_small_factor (o_small_factor),
        .i_large_factor (o_large_factor),
        .o_error_count  (error_count),
        .o_words_due    (words_due)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("Some tests failed");
        $finish;
    end

    always begin
        @(posedge i_clk);
        if (hold_req) begin
            i_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            i_stall  <= 1'b0;
            hold_req = 1'b0;
        end else begin
            i_stall <= !quiet_phase && ($urandom_range(99) < 28);
        end
    end

    task automatic send_n(input logic [N_W-1:0] n);
        if (!quiet_phase)
            while ($urandom_range(99) < 28) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        i_valid   <= 1'b1;
        i_n_value <= n;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [N_W-1:0] directed_n [$];
        int unsigned    pick;
        directed_n = '{16'd0, 16'd1, 16'd3, 16'd5, 16'd2, 16'd4, 16'd6, 16'd7, 16'd9,
                       16'd11, 16'd13, 16'd15, 16'd17, 16'd127, 16'd129, 16'd255,
                       16'd257, 16'd1001, 16'd4095, 16'd8191, 16'd32768, 16'd65534,
                       16'd65535};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_n[k])
            send_n(directed_n[k]);

        for (int k = 0; k < 70; k++) begin
            quiet_phase = (k >= 40 && k < 60);
            pick = $urandom_range(99);
            if (pick < 70)
                send_n(N_W'(2 * $urandom_range(3, 255) + 1));
            else if (pick < 80)
                send_n(N_W'(2 * $urandom_range(256, 2047) + 1));
            else if (pick < 90)
                send_n(N_W'($urandom_range(0, 65535)) & 16'hFFFE);
            else
                send_n(N_W'($urandom_range(0, 5)));
        end
        quiet_phase = 1'b0;

        hold_req = 1'b1;
        for (int k = 0; k < 6; k++)
            send_n(N_W'(2 * $urandom_range(3, 31) + 1));
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && words_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> lemoine_decomposition_search_top.f
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_ctrl.sv
rtl/lds_dpath.sv
rtl/lemoine_decomposition_search_top.sv
test/lds_result_checker.sv
test/tb_lemoine_decomposition_search_top.sv
